[rtl/rvs_pkg.sv]
// Shared package for the RV32IM instruction-step core.
// It holds the memory sizing, the instruction codes, the item and result types and the ALU.
// No dependencies.
`default_nettype none

package rvs_pkg;

  // Memory sizing: four byte lanes of MEM_BYTES/4 entries each.
  localparam int unsigned MEM_BYTES = 65536;
  localparam int unsigned IDX_W     = $clog2(MEM_BYTES);
  localparam int unsigned WORDS     = MEM_BYTES / 4;
  localparam int unsigned WA_W      = $clog2(WORDS);
  localparam logic [31:0] MEM_SPAN  = 32'(MEM_BYTES);

  // Reset value of the memory base and of the program counter.
  localparam logic [31:0] BASE_RST = 32'h8000_0000;

  // Exact halting words.
  localparam logic [31:0] W_ECALL  = 32'h0000_0073;
  localparam logic [31:0] W_EBREAK = 32'h0010_0073;

  // Major opcodes.
  localparam logic [6:0] OPC_IMM   = 7'h13;
  localparam logic [6:0] OPC_OP    = 7'h33;
  localparam logic [6:0] OPC_LUI   = 7'h37;
  localparam logic [6:0] OPC_AUIPC = 7'h17;
  localparam logic [6:0] OPC_JAL   = 7'h6F;
  localparam logic [6:0] OPC_JALR  = 7'h67;
  localparam logic [6:0] OPC_BR    = 7'h63;
  localparam logic [6:0] OPC_LD    = 7'h03;
  localparam logic [6:0] OPC_ST    = 7'h23;

  // funct7 codes.
  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;
  localparam logic [6:0] F7_MUL  = 7'h01;

  typedef enum logic [2:0] {
    STS_EXEC    = 3'd0,
    STS_ECALL   = 3'd1,
    STS_EBREAK  = 3'd2,
    STS_ZERO    = 3'd3,
    STS_ILLEGAL = 3'd4,
    STS_HALTED  = 3'd5,
    STS_LOADED  = 3'd6,
    STS_DROPPED = 3'd7
  } status_t;

  typedef enum logic [0:0] {
    OPN_LOAD = 1'b0,
    OPN_STEP = 1'b1
  } opn_t;

  typedef enum logic [1:0] {
    ACC_NONE  = 2'd0,
    ACC_LOAD  = 2'd1,
    ACC_STORE = 2'd2
  } acc_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_FETCH,
    ST_DECODE,
    ST_EXEC,
    ST_MUL,
    ST_MULC,
    ST_DIV,
    ST_MEM,
    ST_MWAIT,
    ST_WB
  } st_t;

  // One classified input item.
  typedef struct packed {
    opn_t        opn;
    logic [31:0] addr;
    logic [31:0] data;
  } item_t;

  // Request to the divider.
  typedef struct packed {
    logic start;
    logic sgn;
    logic rem;
  } div_req_t;

  // Integer ALU shared by OP-IMM and OP.
  function automatic logic [31:0] alu_op(input logic [2:0] f3, input logic alt,
                                         input logic [31:0] a, input logic [31:0] b);
    logic [4:0]  sh;
    logic [31:0] r;
    sh = b[4:0];
    case (f3)
      3'd0:    r = alt ? a - b : a + b;
      3'd1:    r = a << sh;
      3'd2:    r = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
      3'd3:    r = (a < b) ? 32'd1 : 32'd0;
      3'd4:    r = a ^ b;
      3'd5:    r = alt ? 32'($signed(a) >>> sh) : a >> sh;
      3'd6:    r = a | b;
      default: r = a & b;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/rvs_front.sv]
// Front end of the core: accepts input transfers and classifies them as load or step items.
// Depends on rvs_pkg.
`default_nettype none

module rvs_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [0:0]    in_tuser,   // operation
  input  wire logic [63:0]   in_tdata,   // load_address, load_data
  output logic               push_valid,
  input  wire logic          push_ready,
  output rvs_pkg::item_t     push_item
);
  import rvs_pkg::*;

  logic  slot_vld_r;
  item_t slot_r;

  // The slot takes a new item whenever it is empty or drains this cycle.
  assign in_tready  = !slot_vld_r || push_ready;
  assign push_valid = slot_vld_r;
  assign push_item  = slot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_vld_r <= 1'b0;
    end else if (in_tready) begin
      slot_vld_r <= in_tvalid;
    end
  end

  // Classification into the item record.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      slot_r.opn  <= (in_tuser[0] == 1'b1) ? OPN_STEP : OPN_LOAD;
      slot_r.addr <= in_tdata[31:0];
      slot_r.data <= in_tdata[63:32];
    end
  end

endmodule

`default_nettype wire

[rtl/rvs_fifo.sv]
// Two-entry queue between the front end and the execution back end.
// Depends on rvs_pkg.
`default_nettype none

module rvs_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire rvs_pkg::item_t push_item,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output rvs_pkg::item_t      pop_item
);
  import rvs_pkg::*;

  item_t      ent_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_item   = ent_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop)  rp_r <= ~rp_r;
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) ent_r[wp_r] <= push_item;
  end

endmodule

`default_nettype wire

[rtl/rvs_div.sv]
// Iterative radix-2 divider for DIV, DIVU, REM and REMU, one quotient bit per cycle.
// Depends on rvs_pkg.
`default_nettype none

module rvs_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rvs_pkg::div_req_t req,
  input  wire logic [31:0]       a,
  input  wire logic [31:0]       b,
  output logic                   done,
  output logic [31:0]            result
);
  import rvs_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [31:0] q_r;
  logic [31:0] r_r;
  logic [31:0] mb_r;
  logic [31:0] a_r;
  logic        an_r;
  logic        bn_r;
  logic        zero_r;
  logic        rem_r;
  logic [32:0] trial;
  logic [32:0] diff;

  // One restoring step.
  assign trial = {r_r, q_r[31]};
  assign diff  = trial - {1'b0, mb_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Operands are taken as magnitudes; signs are applied at the end.
  always_ff @(posedge clk) begin
    if (req.start) begin
      an_r   <= req.sgn && a[31];
      bn_r   <= req.sgn && b[31];
      q_r    <= (req.sgn && a[31]) ? 32'd0 - a : a;
      mb_r   <= (req.sgn && b[31]) ? 32'd0 - b : b;
      r_r    <= 32'd0;
      a_r    <= a;
      zero_r <= (b == 32'd0);
      rem_r  <= req.rem;
    end else if (busy_r) begin
      if (!diff[32]) begin
        r_r <= diff[31:0];
        q_r <= {q_r[30:0], 1'b1};
      end else begin
        r_r <= trial[31:0];
        q_r <= {q_r[30:0], 1'b0};
      end
    end
  end

  // Division by zero gives all ones or the dividend; overflow falls out of the sign fix-up.
  always_comb begin
    if (zero_r) begin
      result = rem_r ? a_r : 32'hFFFF_FFFF;
    end else if (rem_r) begin
      result = an_r ? 32'd0 - r_r : r_r;
    end else begin
      result = (an_r != bn_r) ? 32'd0 - q_r : q_r;
    end
  end

  assign done = done_r;

`ifndef SYNTH
  a_start_clears_done: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> !done_r) else $error("divider done while a new division runs");
  a_busy_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(busy_r && done_r)) else $error("divider busy and done together");
  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cnt_r == 5'd31 && !req.start) |=> done_r) else $error("divider missed its end");
`endif

endmodule

`default_nettype wire

[rtl/rvs_back.sv]
// Back end of the core: byte-lane memory, register file, sequencer and result register.
// Depends on rvs_pkg and rvs_div.
`default_nettype none

module rvs_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_wr,
  input  wire logic [31:0]    cfg_data,
  input  wire logic           q_valid,
  output logic                q_ready,
  input  wire rvs_pkg::item_t q_item,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output logic [7:0]          out_tuser,   // status
  output logic [207:0]        out_tdata    // exec_pc .. mem_fault, see top level
);
  import rvs_pkg::*;

  st_t st_r, st_nxt;

  // Architectural state.
  logic [31:0] base_r;
  logic [31:0] pc_r;
  logic        halted_r;
  logic [WA_W-1:0] clr_r;

  // Per-item working registers.
  item_t       item_r;
  status_t     status_r;
  logic [31:0] xpc_r;
  logic [31:0] w_r;
  logic [31:0] npc_r;
  logic [31:0] val_r;
  logic        wr_r;
  logic        taken_r;
  acc_t        acc_r;
  logic [31:0] addr_r;
  logic [31:0] data_r;
  logic [2:0]  size_r;
  logic        fault_r;
  logic [1:0]  off_r;
  logic        rok_r;
  logic [31:0] a_r;
  logic [31:0] b_r;
  logic [63:0] p_r;

  // Result register.
  logic         out_vld_r;
  logic [7:0]   out_user_r;
  logic [207:0] out_data_r;
  logic [207:0] res_data;

  // Byte lanes.
  logic [7:0]      lane_mem0 [WORDS];
  logic [7:0]      lane_mem1 [WORDS];
  logic [7:0]      lane_mem2 [WORDS];
  logic [7:0]      lane_mem3 [WORDS];
  logic [7:0]      ln_rd_r [4];
  logic [WA_W-1:0] ln_a [4];
  logic [7:0]      ln_wd [4];
  logic [3:0]      ln_we;

  // Register file with reset-valid bits.
  logic [31:0] rf_mem [32];
  logic [31:0] rf_vld_r;
  logic [31:0] rf_a_r;
  logic [31:0] rf_b_r;
  logic        rf_we;
  logic [4:0]  rf_wa;

  // Memory access port signals.
  logic [31:0] acc_addr;
  logic [2:0]  acc_n;
  logic [31:0] acc_wval;
  logic        acc_wen;
  logic [31:0] idx32;
  logic        acc_ok;
  logic [31:0] asm_word;
  logic [31:0] w_dec;

  // Decode of the fetched word.
  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [4:0]  rd;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_b;
  logic [31:0] imm_j;
  logic [31:0] imm_u;

  // Execute-stage results.
  logic        ex_ill;
  logic        ex_wr;
  logic [31:0] ex_val;
  logic [31:0] ex_npc;
  logic        ex_taken;
  acc_t        ex_acc;
  logic [31:0] ex_addr;
  logic [31:0] ex_data;
  logic [2:0]  ex_size;
  logic        ex_mul;
  logic        ex_div;

  div_req_t    div_req;
  logic        div_done;
  logic [31:0] div_res;
  logic        wb_go;
  logic        is_exec;
  logic [31:0] ld_raw;
  logic [31:0] ld_val;
  logic [31:0] mul_hi;

  rvs_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (div_req),
    .a      (rf_a_r),
    .b      (rf_b_r),
    .done   (div_done),
    .result (div_res)
  );

  assign q_ready = (st_r == ST_IDLE);
  assign wb_go   = !out_vld_r || out_tready;

  // Field split of the word in execute.
  assign opc   = w_r[6:0];
  assign f3    = w_r[14:12];
  assign f7    = w_r[31:25];
  assign rd    = w_r[11:7];
  assign imm_i = {{20{w_r[31]}}, w_r[31:20]};
  assign imm_s = {{20{w_r[31]}}, w_r[31:25], w_r[11:7]};
  assign imm_b = {{19{w_r[31]}}, w_r[31], w_r[7], w_r[30:25], w_r[11:8], 1'b0};
  assign imm_j = {{11{w_r[31]}}, w_r[31], w_r[19:12], w_r[20], w_r[30:21], 1'b0};
  assign imm_u = {w_r[31:12], 12'd0};

  // Address selection for the single memory port.
  always_comb begin
    acc_addr = pc_r;
    acc_n    = 3'd4;
    acc_wval = item_r.data;
    acc_wen  = 1'b0;
    case (st_r)
      ST_LOAD: begin
        acc_addr = item_r.addr;
        acc_wen  = 1'b1;
      end
      ST_MEM: begin
        acc_addr = addr_r;
        acc_n    = size_r;
        acc_wval = data_r;
        acc_wen  = (acc_r == ACC_STORE);
      end
      default: begin
        acc_addr = pc_r;
      end
    endcase
  end

  assign idx32  = acc_addr - base_r;
  assign acc_ok = (idx32 <= (MEM_SPAN - {29'd0, acc_n}));

  // Each lane takes the byte of the access that falls into it.
  always_comb begin
    logic [1:0]     k_v;
    logic [IDX_W:0] j_v;
    for (int l = 0; l < 4; l++) begin
      k_v = 2'(l) - idx32[1:0];
      j_v = {1'b0, idx32[IDX_W-1:0]} + (IDX_W+1)'(k_v);
      if (st_r == ST_CLEAR) begin
        ln_a[l]  = clr_r;
        ln_we[l] = 1'b1;
        ln_wd[l] = 8'd0;
      end else begin
        ln_a[l]  = j_v[IDX_W-1:2];
        ln_we[l] = acc_wen && acc_ok && ({1'b0, k_v} < acc_n);
        ln_wd[l] = 8'(acc_wval >> {k_v, 3'b000});
      end
    end
  end

  // Lane memories.
  always_ff @(posedge clk) begin
    if (ln_we[0]) lane_mem0[ln_a[0]] <= ln_wd[0];
    ln_rd_r[0] <= lane_mem0[ln_a[0]];
  end
  always_ff @(posedge clk) begin
    if (ln_we[1]) lane_mem1[ln_a[1]] <= ln_wd[1];
    ln_rd_r[1] <= lane_mem1[ln_a[1]];
  end
  always_ff @(posedge clk) begin
    if (ln_we[2]) lane_mem2[ln_a[2]] <= ln_wd[2];
    ln_rd_r[2] <= lane_mem2[ln_a[2]];
  end
  always_ff @(posedge clk) begin
    if (ln_we[3]) lane_mem3[ln_a[3]] <= ln_wd[3];
    ln_rd_r[3] <= lane_mem3[ln_a[3]];
  end

  // Rotate lane bytes back into access order.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      asm_word[8*k +: 8] = ln_rd_r[off_r + 2'(k)];
    end
  end

  assign w_dec = rok_r ? asm_word : 32'd0;

  // Register file: two registered reads, one write at write-back.
  assign rf_we = (st_r == ST_WB) && wb_go && (status_r == STS_EXEC) && wr_r && (rd != 5'd0);
  assign rf_wa = rd;

  always_ff @(posedge clk) begin
    if (rf_we) rf_mem[rf_wa] <= val_r;
    rf_a_r <= rf_vld_r[w_dec[19:15]] ? rf_mem[w_dec[19:15]] : 32'd0;
    rf_b_r <= rf_vld_r[w_dec[24:20]] ? rf_mem[w_dec[24:20]] : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= 32'd0;
    end else if (rf_we) begin
      rf_vld_r[rf_wa] <= 1'b1;
    end
  end

  // Instruction execute.
  always_comb begin
    ex_ill   = 1'b0;
    ex_wr    = 1'b0;
    ex_val   = 32'd0;
    ex_npc   = pc_r + 32'd4;
    ex_taken = 1'b0;
    ex_acc   = ACC_NONE;
    ex_addr  = 32'd0;
    ex_data  = 32'd0;
    ex_size  = 3'd0;
    ex_mul   = 1'b0;
    ex_div   = 1'b0;
    case (opc)
      OPC_IMM: begin
        if (f3 == 3'd1 && f7 != F7_BASE) begin
          ex_ill = 1'b1;
        end else if (f3 == 3'd5 && f7 != F7_BASE && f7 != F7_ALT) begin
          ex_ill = 1'b1;
        end else begin
          ex_val = alu_op(f3, f3 == 3'd5 && f7 == F7_ALT, rf_a_r, imm_i);
          ex_wr  = 1'b1;
        end
      end
      OPC_OP: begin
        if (f7 == F7_BASE) begin
          ex_val = alu_op(f3, 1'b0, rf_a_r, rf_b_r);
          ex_wr  = 1'b1;
        end else if (f7 == F7_ALT && (f3 == 3'd0 || f3 == 3'd5)) begin
          ex_val = alu_op(f3, 1'b1, rf_a_r, rf_b_r);
          ex_wr  = 1'b1;
        end else if (f7 == F7_MUL) begin
          ex_wr  = 1'b1;
          ex_mul = !f3[2];
          ex_div = f3[2];
        end else begin
          ex_ill = 1'b1;
        end
      end
      OPC_LUI: begin
        ex_val = imm_u;
        ex_wr  = 1'b1;
      end
      OPC_AUIPC: begin
        ex_val = pc_r + imm_u;
        ex_wr  = 1'b1;
      end
      OPC_JAL: begin
        ex_val = pc_r + 32'd4;
        ex_wr  = 1'b1;
        ex_npc = pc_r + imm_j;
      end
      OPC_JALR: begin
        if (f3 != 3'd0) begin
          ex_ill = 1'b1;
        end else begin
          ex_val = pc_r + 32'd4;
          ex_wr  = 1'b1;
          ex_npc = (rf_a_r + imm_i) & 32'hFFFF_FFFE;
        end
      end
      OPC_BR: begin
        case (f3)
          3'd0:    ex_taken = (rf_a_r == rf_b_r);
          3'd1:    ex_taken = (rf_a_r != rf_b_r);
          3'd4:    ex_taken = ($signed(rf_a_r) < $signed(rf_b_r));
          3'd5:    ex_taken = !($signed(rf_a_r) < $signed(rf_b_r));
          3'd6:    ex_taken = (rf_a_r < rf_b_r);
          3'd7:    ex_taken = (rf_a_r >= rf_b_r);
          default: ex_ill   = 1'b1;
        endcase
        if (ex_taken) ex_npc = pc_r + imm_b;
      end
      OPC_LD: begin
        ex_addr = rf_a_r + imm_i;
        ex_wr   = 1'b1;
        ex_acc  = ACC_LOAD;
        case (f3)
          3'd0, 3'd4: ex_size = 3'd1;
          3'd1, 3'd5: ex_size = 3'd2;
          3'd2:       ex_size = 3'd4;
          default:    ex_ill  = 1'b1;
        endcase
      end
      OPC_ST: begin
        ex_addr = rf_a_r + imm_s;
        ex_acc  = ACC_STORE;
        case (f3)
          3'd0: begin
            ex_size = 3'd1;
            ex_data = {24'd0, rf_b_r[7:0]};
          end
          3'd1: begin
            ex_size = 3'd2;
            ex_data = {16'd0, rf_b_r[15:0]};
          end
          3'd2: begin
            ex_size = 3'd4;
            ex_data = rf_b_r;
          end
          default: ex_ill = 1'b1;
        endcase
      end
      default: ex_ill = 1'b1;
    endcase
  end

  assign div_req.start = (st_r == ST_EXEC) && !ex_ill && ex_div;
  assign div_req.sgn   = !f3[0];
  assign div_req.rem   = f3[1];

  // Load data: fault reads zero, then size and extension.
  assign ld_raw = rok_r ? asm_word : 32'd0;
  always_comb begin
    case (f3)
      3'd0:    ld_val = {{24{ld_raw[7]}}, ld_raw[7:0]};
      3'd1:    ld_val = {{16{ld_raw[15]}}, ld_raw[15:0]};
      3'd4:    ld_val = {24'd0, ld_raw[7:0]};
      3'd5:    ld_val = {16'd0, ld_raw[15:0]};
      default: ld_val = ld_raw;
    endcase
  end

  // Product word: low half for MUL, high half with a fix-up for the signed variants.
  always_comb begin
    case (f3[1:0])
      2'd0:    mul_hi = p_r[31:0];
      2'd1:    mul_hi = p_r[63:32] - (a_r[31] ? b_r : 32'd0) - (b_r[31] ? a_r : 32'd0);
      2'd2:    mul_hi = p_r[63:32] - (a_r[31] ? b_r : 32'd0);
      default: mul_hi = p_r[63:32];
    endcase
  end

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_CLEAR:  if (clr_r == WA_W'(WORDS - 1)) st_nxt = ST_IDLE;
      ST_IDLE: begin
        if (q_valid) begin
          if (q_item.opn == OPN_LOAD) st_nxt = ST_LOAD;
          else if (halted_r)          st_nxt = ST_WB;
          else                        st_nxt = ST_FETCH;
        end
      end
      ST_LOAD:   st_nxt = ST_WB;
      ST_FETCH:  st_nxt = ST_DECODE;
      ST_DECODE: begin
        if (w_dec == W_ECALL || w_dec == W_EBREAK || w_dec == 32'd0) st_nxt = ST_WB;
        else st_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (ex_ill)                  st_nxt = ST_WB;
        else if (ex_mul)             st_nxt = ST_MUL;
        else if (ex_div)             st_nxt = ST_DIV;
        else if (ex_acc != ACC_NONE) st_nxt = ST_MEM;
        else                         st_nxt = ST_WB;
      end
      ST_MUL:    st_nxt = ST_MULC;
      ST_MULC:   st_nxt = ST_WB;
      ST_DIV:    if (div_done) st_nxt = ST_WB;
      ST_MEM:    st_nxt = (acc_r == ACC_LOAD) ? ST_MWAIT : ST_WB;
      ST_MWAIT:  st_nxt = ST_WB;
      ST_WB:     if (wb_go) st_nxt = ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLEAR;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Control state: base, program counter, halt flag, clearing counter, result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r    <= BASE_RST;
      pc_r      <= BASE_RST;
      halted_r  <= 1'b0;
      clr_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_wr) base_r <= cfg_data;
      if (st_r == ST_CLEAR) clr_r <= clr_r + WA_W'(1);
      if (st_r == ST_WB && wb_go) begin
        out_vld_r <= 1'b1;
        if (status_r == STS_EXEC) pc_r <= npc_r;
        if (status_r == STS_ECALL || status_r == STS_EBREAK ||
            status_r == STS_ZERO || status_r == STS_ILLEGAL) begin
          halted_r <= 1'b1;
        end
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Working registers of the item in flight.
  always_ff @(posedge clk) begin
    case (st_r)
      ST_IDLE: begin
        item_r   <= q_item;
        xpc_r    <= (q_item.opn == OPN_STEP) ? pc_r : 32'd0;
        w_r      <= 32'd0;
        status_r <= STS_HALTED;
        wr_r     <= 1'b0;
        taken_r  <= 1'b0;
        acc_r    <= ACC_NONE;
        fault_r  <= 1'b0;
      end
      ST_LOAD: status_r <= acc_ok ? STS_LOADED : STS_DROPPED;
      ST_FETCH: begin
        off_r <= idx32[1:0];
        rok_r <= acc_ok;
      end
      ST_DECODE: begin
        w_r <= w_dec;
        if (w_dec == W_ECALL)       status_r <= STS_ECALL;
        else if (w_dec == W_EBREAK) status_r <= STS_EBREAK;
        else if (w_dec == 32'd0)    status_r <= STS_ZERO;
        else                        status_r <= STS_EXEC;
      end
      ST_EXEC: begin
        if (ex_ill) status_r <= STS_ILLEGAL;
        wr_r    <= ex_wr;
        val_r   <= ex_val;
        npc_r   <= ex_npc;
        taken_r <= ex_taken;
        acc_r   <= ex_acc;
        addr_r  <= ex_addr;
        data_r  <= ex_data;
        size_r  <= ex_size;
        a_r     <= rf_a_r;
        b_r     <= rf_b_r;
      end
      ST_MUL:  p_r <= a_r * b_r;
      ST_MULC: val_r <= mul_hi;
      ST_DIV:  val_r <= div_res;
      ST_MEM: begin
        fault_r <= !acc_ok;
        off_r   <= idx32[1:0];
        rok_r   <= acc_ok;
      end
      ST_MWAIT: begin
        data_r <= ld_val;
        val_r  <= ld_val;
      end
      default: begin
        val_r <= val_r;
      end
    endcase
  end

  // Result record; fields without meaning are zero.
  assign is_exec = (status_r == STS_EXEC);

  always_comb begin
    res_data         = '0;
    res_data[31:0]   = xpc_r;
    res_data[63:32]  = w_r;
    res_data[95:64]  = is_exec ? npc_r : pc_r;
    if (is_exec && wr_r && rd != 5'd0) begin
      res_data[96]      = 1'b1;
      res_data[101:97]  = rd;
      res_data[133:102] = val_r;
    end
    if (is_exec && acc_r != ACC_NONE) begin
      res_data[135:134] = acc_r;
      res_data[167:136] = addr_r;
      res_data[199:168] = data_r;
      res_data[201]     = fault_r;
    end
    res_data[200] = is_exec && taken_r;
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_WB && wb_go) begin
      out_user_r <= {5'd0, status_r};
      out_data_r <= res_data;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_user_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTH
  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_CLEAR) |-> !(q_valid && q_ready)) else $error("item taken during clearing");
  a_x0_kept: assert property (@(posedge clk) disable iff (!rst_n)
    rf_we |-> (rf_wa != 5'd0)) else $error("write to x0");
  a_halted_no_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_WB && halted_r && item_r.opn == OPN_STEP) |-> (status_r == STS_HALTED))
    else $error("halted core executed an instruction");
`endif

endmodule

`default_nettype wire

[rtl/rv32im_instruction_step.sv]
// Top level of the RV32IM instruction-step core.
// Depends on rvs_pkg, rvs_front, rvs_fifo and rvs_back.
//
// Usage: each transfer on the in_ channel is a load item (in_tuser = 0), which writes the
// 32-bit word in_tdata[63:32] little-endian at byte address in_tdata[31:0], or a step item
// (in_tuser = 1), which, unless halted, executes one instruction at the program counter.
// Every item gives exactly one transfer on the out_ channel, in order.
// The cfg_ channel writes the memory base; write it only while the core is idle.
// A multiply passes through states ST_MUL and ST_MULC after execute, and a divide or
// remainder waits in ST_DIV on the one-bit-per-cycle divider. Items are worked one at a
// time by the back-end sequencer; the front slot and a two-entry queue keep accepting
// while it works.
// Reset: the byte memory is swept to zero, one entry of each of the four byte lanes per
// cycle, over all MEM_BYTES/4 entries (16384); items wait in the queue during that sweep.
// The program counter returns to the base, registers read zero and the halt flag clears.
// When the receiver stalls, the finished result holds in the output register and the
// next item runs up to write-back behind it.
`default_nettype none

module rv32im_instruction_step (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_tvalid,
  output logic               cfg_tready,
  input  wire logic [31:0]   cfg_tdata,   // memory_base
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [0:0]    in_tuser,    // operation
  input  wire logic [63:0]   in_tdata,    // load_address, load_data
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [7:0]         out_tuser,   // status, zero fill
  output logic [207:0]       out_tdata    // exec_pc, instr_word, next_pc, rd_written,
                                          // rd_index, rd_value, mem_access, mem_address,
                                          // mem_data, branch_taken, mem_fault, zero fill
);
  import rvs_pkg::*;

  logic  fr_valid;
  logic  fr_ready;
  item_t fr_item;
  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  // The base register accepts a transfer every cycle.
  assign cfg_tready = 1'b1;

  rvs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_item  (fr_item)
  );

  rvs_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_item  (fr_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  rvs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr     (cfg_tvalid && cfg_tready),
    .cfg_data   (cfg_tdata),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

[test/tb_top.sv]
// Self-checking testbench for the RV32IM instruction-step core (rv32im_instruction_step).
// It predicts every result from its own copy of the core state and drives random programs.
// Depends on rvs_pkg for the port types and codes.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rvs_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  // One result as the core reports it.
  typedef struct {
    status_t     status;
    logic [31:0] exec_pc;
    logic [31:0] fetched;
    logic [31:0] next_pc;
    logic        rd_wr;
    logic [4:0]  rd_idx;
    logic [31:0] rd_val;
    acc_t        acc;
    logic [31:0] maddr;
    logic [31:0] mdata;
    logic        taken;
    logic        fault;
  } step_rec_t;

  logic          clk;
  logic          rst_n;
  logic          cfg_tvalid;
  logic          cfg_tready;
  logic [31:0]   cfg_tdata;   // memory_base
  logic          in_tvalid;
  logic          in_tready;
  logic [0:0]    in_tuser;    // operation
  logic [63:0]   in_tdata;    // load_address, load_data
  logic          out_tvalid;
  logic          out_tready;
  logic [7:0]    out_tuser;   // status, zero fill
  logic [207:0]  out_tdata;   // exec_pc, instr_word, next_pc, rd_written, rd_index, rd_value,
                              // mem_access, mem_address, mem_data, branch_taken, mem_fault

  // Predicted core state.
  logic [31:0] core_base;
  logic [31:0] core_pc;
  logic [31:0] core_regs [32];
  logic [7:0]  core_mem [0:MEM_BYTES-1];
  logic        core_halt;

  step_rec_t pending_results[$];
  int        error_count;
  int        cycle_count;
  int        steps_sent;
  int        loads_sent;
  int        results_seen;
  logic      idle_on;

  rv32im_instruction_step dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Overall limit on the run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver stalls in random bursts while idling is enabled.
  initial begin
    out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- memory and arithmetic

  function automatic logic in_range(input logic [31:0] addr, input int n);
    return (addr - core_base) <= 32'(MEM_BYTES - n);
  endfunction

  function automatic logic [31:0] mem_get(input logic [31:0] addr, input int n,
                                          output logic fault);
    logic [31:0] idx;
    logic [31:0] v;
    idx   = addr - core_base;
    v     = '0;
    fault = 1'b0;
    if (!in_range(addr, n)) begin
      fault = 1'b1;
      return '0;
    end
    for (int k = 0; k < n; k++) v |= 32'(core_mem[idx + k]) << (8 * k);
    return v;
  endfunction

  function automatic logic mem_put(input logic [31:0] addr, input int n,
                                   input logic [31:0] v);
    logic [31:0] idx;
    idx = addr - core_base;
    if (!in_range(addr, n)) return 1'b0;
    for (int k = 0; k < n; k++) core_mem[idx + k] = v[8*k +: 8];
    return 1'b1;
  endfunction

  function automatic logic [31:0] alu_result(input logic [2:0] f3, input logic alt,
                                             input logic [31:0] a, input logic [31:0] b);
    logic [4:0] sh;
    sh = b[4:0];
    case (f3)
      3'd0: return alt ? a - b : a + b;
      3'd1: return a << sh;
      3'd2: return {31'b0, (a ^ 32'h8000_0000) < (b ^ 32'h8000_0000)};
      3'd3: return {31'b0, a < b};
      3'd4: return a ^ b;
      3'd5: return (alt && a[31]) ? ~((~a) >> sh) : a >> sh;
      3'd6: return a | b;
      default: return a & b;
    endcase
  endfunction

  function automatic logic [31:0] muldiv_result(input logic [2:0] f3, input logic [31:0] a,
                                                input logic [31:0] b);
    logic [63:0] p;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [31:0] q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    case (f3)
      3'd0: return a * b;
      3'd1: begin
        p = {{32{a[31]}}, a} * {{32{b[31]}}, b};
        return p[63:32];
      end
      3'd2: begin
        p = {{32{a[31]}}, a} * {32'b0, b};
        return p[63:32];
      end
      3'd3: begin
        p = {32'b0, a} * {32'b0, b};
        return p[63:32];
      end
      3'd4: begin
        if (b == 0) return 32'hFFFF_FFFF;
        if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) return a;
        q = ma / mb;
        return (a[31] ^ b[31]) ? -q : q;
      end
      3'd5: return (b == 0) ? 32'hFFFF_FFFF : a / b;
      3'd6: begin
        if (b == 0) return a;
        if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF) return '0;
        q = ma % mb;
        return a[31] ? -q : q;
      end
      default: return (b == 0) ? a : a % b;
    endcase
  endfunction

  // ---------------------------------------------------------------- prediction

  // Works out the result of one accepted item and advances the predicted state.
  function automatic void execute_item(input opn_t opn, input logic [63:0] payload,
                                       output step_rec_t r);
    logic [31:0] w, a, b, npc, val, addr, data;
    logic [6:0]  opc, f7;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic        wr, bad, fault;
    int          size;
    r.status = STS_EXEC;
    r.exec_pc = '0; r.fetched = '0; r.next_pc = core_pc;
    r.rd_wr = 1'b0; r.rd_idx = '0; r.rd_val = '0;
    r.acc = ACC_NONE; r.maddr = '0; r.mdata = '0; r.taken = 1'b0; r.fault = 1'b0;

    // A program word is written even while halted.
    if (opn == OPN_LOAD) begin
      r.status = mem_put(payload[31:0], 4, payload[63:32]) ? STS_LOADED : STS_DROPPED;
      return;
    end
    r.exec_pc = core_pc;
    if (core_halt) begin
      r.status = STS_HALTED;
      return;
    end

    // Fetch; outside memory the word reads as zero.
    w = mem_get(core_pc, 4, fault);
    r.fetched = w;
    if (w == W_ECALL || w == W_EBREAK || w == 32'h0) begin
      r.status = (w == W_ECALL) ? STS_ECALL : (w == W_EBREAK) ? STS_EBREAK : STS_ZERO;
      core_halt = 1'b1;
      return;
    end

    opc = w[6:0]; rd = w[11:7]; f3 = w[14:12]; f7 = w[31:25];
    a = core_regs[w[19:15]];
    b = core_regs[w[24:20]];
    npc = core_pc + 4;
    val = '0; addr = '0; data = '0; size = 0;
    wr = 1'b0; bad = 1'b0; fault = 1'b0;

    case (opc)
      OPC_IMM: begin
        if (f3 == 3'd1 && f7 != F7_BASE) bad = 1'b1;
        else if (f3 == 3'd5 && f7 != F7_BASE && f7 != F7_ALT) bad = 1'b1;
        else begin
          val = alu_result(f3, f3 == 3'd5 && f7 == F7_ALT, a, {{20{w[31]}}, w[31:20]});
          wr = 1'b1;
        end
      end
      OPC_OP: begin
        if (f7 == F7_BASE) val = alu_result(f3, 1'b0, a, b);
        else if (f7 == F7_ALT && (f3 == 3'd0 || f3 == 3'd5)) val = alu_result(f3, 1'b1, a, b);
        else if (f7 == F7_MUL) val = muldiv_result(f3, a, b);
        else bad = 1'b1;
        wr = !bad;
      end
      OPC_LUI: begin
        val = {w[31:12], 12'b0};
        wr = 1'b1;
      end
      OPC_AUIPC: begin
        val = core_pc + {w[31:12], 12'b0};
        wr = 1'b1;
      end
      OPC_JAL: begin
        val = core_pc + 4;
        wr = 1'b1;
        npc = core_pc + {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
      end
      OPC_JALR: begin
        if (f3 != 3'd0) bad = 1'b1;
        else begin
          val = core_pc + 4;
          wr = 1'b1;
          npc = (a + {{20{w[31]}}, w[31:20]}) & ~32'd1;
        end
      end
      OPC_BR: begin
        case (f3)
          3'd0: r.taken = (a == b);
          3'd1: r.taken = (a != b);
          3'd4: r.taken = (a ^ 32'h8000_0000) < (b ^ 32'h8000_0000);
          3'd5: r.taken = (a ^ 32'h8000_0000) >= (b ^ 32'h8000_0000);
          3'd6: r.taken = (a < b);
          3'd7: r.taken = (a >= b);
          default: bad = 1'b1;
        endcase
        if (r.taken) npc = core_pc + {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
      end
      OPC_LD: begin
        addr = a + {{20{w[31]}}, w[31:20]};
        case (f3)
          3'd0, 3'd4: size = 1;
          3'd1, 3'd5: size = 2;
          3'd2:       size = 4;
          default:    bad = 1'b1;
        endcase
        if (!bad) begin
          data = mem_get(addr, size, fault);
          if (f3 == 3'd0) data = {{24{data[7]}}, data[7:0]};
          if (f3 == 3'd1) data = {{16{data[15]}}, data[15:0]};
          val = data;
          wr = 1'b1;
          r.acc = ACC_LOAD;
        end
      end
      OPC_ST: begin
        addr = a + {{20{w[31]}}, w[31:25], w[11:7]};
        if (f3 > 3'd2) bad = 1'b1;
        else begin
          size = 1 << f3;
          data = (size == 4) ? b : (size == 2) ? {16'b0, b[15:0]} : {24'b0, b[7:0]};
          r.acc = ACC_STORE;
        end
      end
      default: bad = 1'b1;
    endcase

    // Illegal encodings halt without side effects.
    if (bad) begin
      r.status = STS_ILLEGAL;
      r.acc = ACC_NONE;
      r.taken = 1'b0;
      core_halt = 1'b1;
      return;
    end
    if (r.acc == ACC_STORE) fault = !mem_put(addr, size, data);
    if (wr && rd != 0) begin
      core_regs[rd] = val;
      r.rd_wr = 1'b1; r.rd_idx = rd; r.rd_val = val;
    end
    core_pc = npc;
    r.next_pc = npc;
    if (r.acc != ACC_NONE) begin
      r.maddr = addr; r.mdata = data; r.fault = fault;
    end
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  // Compare each result transfer with the oldest prediction.
  always @(posedge clk) begin
    step_rec_t e;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result transfer with no prediction outstanding");
      end else begin
        e = pending_results.pop_front();
        check_field("status", 32'(out_tuser[2:0]), 32'(e.status));
        check_field("exec_pc", out_tdata[31:0], e.exec_pc);
        check_field("instr_word", out_tdata[63:32], e.fetched);
        check_field("next_pc", out_tdata[95:64], e.next_pc);
        check_field("rd_written", 32'(out_tdata[96]), 32'(e.rd_wr));
        check_field("rd_index", 32'(out_tdata[101:97]), 32'(e.rd_idx));
        check_field("rd_value", out_tdata[133:102], e.rd_val);
        check_field("mem_access", 32'(out_tdata[135:134]), 32'(e.acc));
        check_field("mem_address", out_tdata[167:136], e.maddr);
        check_field("mem_data", out_tdata[199:168], e.mdata);
        check_field("branch_taken", 32'(out_tdata[200]), 32'(e.taken));
        check_field("mem_fault", 32'(out_tdata[201]), 32'(e.fault));
      end
    end
  end

  // ---------------------------------------------------------------- stimulus helpers

  // Sends one item; valid stays high into the next item unless a gap is taken.
  task automatic send_item(input opn_t opn, input logic [63:0] payload);
    step_rec_t r;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= opn;
    in_tdata  <= payload;
    do @(posedge clk); while (!in_tready);
    execute_item(opn, payload, r);
    pending_results.push_back(r);
    if (opn == OPN_LOAD) loads_sent++;
    else steps_sent++;
  endtask

  // Places a word at the program counter and executes it.
  task automatic run_word(input logic [31:0] w);
    send_item(OPN_LOAD, {w, core_pc});
    send_item(OPN_STEP, {$urandom, $urandom});
  endtask

  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_base(input logic [31:0] value);
    wait_quiet();
    cfg_tvalid <= 1'b1;
    cfg_tdata  <= value;
    do @(posedge clk); while (!cfg_tready);
    cfg_tvalid <= 1'b0;
    core_base = value;
  endtask

  function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
                                        input logic [4:0] rs1, input logic [2:0] f3,
                                        input logic [4:0] rd);
    return {f7, rs2, rs1, f3, rd, OPC_OP};
  endfunction

  function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
                                        input logic [2:0] f3, input logic [4:0] rd,
                                        input logic [6:0] opc);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_s(input logic [11:0] imm, input logic [4:0] rs2,
                                        input logic [4:0] rs1, input logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_ST};
  endfunction

  function automatic logic [31:0] enc_b(input logic [12:0] off, input logic [4:0] rs2,
                                        input logic [4:0] rs1, input logic [2:0] f3);
    return {off[12], off[10:5], rs2, rs1, f3, off[4:1], off[11], OPC_BR};
  endfunction

  function automatic logic [31:0] enc_j(input logic [20:0] off, input logic [4:0] rd);
    return {off[20], off[10:1], off[11], off[19:12], rd, OPC_JAL};
  endfunction

  // A random legal instruction whose next fetch stays inside memory.
  function automatic logic [31:0] random_legal();
    logic [31:0] imm, t;
    logic [4:0]  rd, rs1, rs2, ptr;
    logic [2:0]  f3;
    logic [12:0] bo;
    logic [20:0] jo;
    int          pick;
    imm = $urandom; rd = $urandom; rs1 = $urandom; rs2 = $urandom; f3 = $urandom;
    ptr = $urandom_range(5, 7);
    // Near the top of memory, jump back down.
    if (!in_range(core_pc + 4, 4)) return enc_j(21'h1F_FC00, rd);
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      if (f3 == 3'd1) return enc_i({7'h0, imm[4:0]}, rs1, f3, rd, OPC_IMM);
      if (f3 == 3'd5) return enc_i({imm[9] ? F7_ALT : F7_BASE, imm[4:0]}, rs1, f3, rd, OPC_IMM);
      return enc_i(imm[31:20], rs1, f3, rd, OPC_IMM);
    end else if (pick < 42) begin
      case ($urandom_range(0, 2))
        0: return enc_r(F7_BASE, rs2, rs1, f3, rd);
        1: return enc_r(F7_MUL, rs2, rs1, f3, rd);
        default: return enc_r(F7_ALT, rs2, rs1, imm[0] ? 3'd0 : 3'd5, rd);
      endcase
    end else if (pick < 49) begin
      return {imm[31:12], rd, OPC_LUI};
    end else if (pick < 57) begin
      return {imm[0] ? 20'h0 : 20'(imm[3:1]), ptr, OPC_AUIPC};
    end else if (pick < 64) begin
      jo = {{8{imm[12]}}, imm[12:1], 1'b0};
      t = core_pc + {{11{jo[20]}}, jo};
      if (!in_range(t, 4)) jo = '0;
      return enc_j(jo, rd);
    end else if (pick < 70) begin
      if ($urandom_range(0, 3) != 0) rs1 = ptr;
      t = (core_regs[rs1] + {{20{imm[11]}}, imm[11:0]}) & ~32'd1;
      if (!in_range(t, 4)) return enc_j('0, rd);
      return enc_i(imm[11:0], rs1, 3'd0, rd, OPC_JALR);
    end else if (pick < 82) begin
      if (f3 == 3'd2 || f3 == 3'd3) f3 = {1'b1, f3[0], imm[20]};
      if (imm[21]) rs2 = rs1;
      bo = {imm[11:0], 1'b0};
      t = core_pc + {{19{bo[12]}}, bo};
      if (!in_range(t, 4)) bo = '0;
      return enc_b(bo, rs2, rs1, f3);
    end else if (pick < 91) begin
      if (f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7) f3 = 3'd2;
      if ($urandom_range(0, 4) != 0) rs1 = ptr;
      return enc_i(imm[11:0], rs1, f3, rd, OPC_LD);
    end
    if ($urandom_range(0, 4) != 0) rs1 = ptr;
    return enc_s(imm[11:0], rs2, rs1, 3'($urandom_range(0, 2)));
  endfunction

  // ---------------------------------------------------------------- tests

  // Arithmetic corner cases, x0, memory access and a register jump.
  task automatic test_directed();
    run_word({20'h80000, 5'd1, OPC_LUI});                 // x1 = most negative
    run_word(enc_i(12'hFFF, 5'd0, 3'd0, 5'd2, OPC_IMM));  // x2 = -1
    run_word(enc_r(F7_MUL, 5'd2, 5'd1, 3'd4, 5'd12));     // signed divide overflow
    run_word(enc_r(F7_MUL, 5'd2, 5'd1, 3'd6, 5'd15));     // signed remainder overflow
    run_word(enc_r(F7_MUL, 5'd0, 5'd1, 3'd5, 5'd13));     // unsigned divide by zero
    run_word(enc_r(F7_MUL, 5'd0, 5'd1, 3'd6, 5'd16));     // remainder by zero
    run_word(enc_r(F7_MUL, 5'd2, 5'd1, 3'd1, 5'd9));      // high product, both signed
    run_word(enc_r(F7_BASE, 5'd2, 5'd1, 3'd0, 5'd0));     // write to x0 is discarded
    run_word({20'h0, 5'd5, OPC_AUIPC});
    run_word(enc_s(12'd64, 5'd2, 5'd5, 3'd0));
    run_word(enc_i(12'd64, 5'd5, 3'd1, 5'd8, OPC_LD));
    run_word(enc_i(12'd0, 5'd2, 3'd2, 5'd10, OPC_LD));    // load outside memory
    run_word(enc_i(12'd1, 5'd5, 3'd0, 5'd11, OPC_JALR));
  endtask

  // Extreme memory bases with word loads at and just past both ends.
  task automatic test_base_extremes();
    set_base(32'h0000_0000);
    send_item(OPN_LOAD, {32'hFFFF_FFFF, 32'h0000_0000});
    send_item(OPN_LOAD, {32'hA5A5_5A5A, 32'(MEM_BYTES - 4)});
    send_item(OPN_LOAD, {32'h1234_5678, 32'(MEM_BYTES - 3)});
    send_item(OPN_LOAD, {32'h0000_0000, 32'hFFFF_FFFF});
    set_base(32'hFFFF_FFFF);
    send_item(OPN_LOAD, {32'h0BAD_F00D, 32'hFFFF_FFFF});
    send_item(OPN_LOAD, {32'h5555_AAAA, 32'(MEM_BYTES - 5)});
    send_item(OPN_LOAD, {32'h7777_8888, 32'(MEM_BYTES - 4)});
    set_base(core_pc - 32'($urandom_range(0, MEM_BYTES - 4)));
  endtask

  // Random legal programs with stray and in-range word loads mixed in.
  task automatic test_random_program(input int count);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 15))
        0: send_item(OPN_LOAD, {$urandom, $urandom});
        1: send_item(OPN_LOAD, {$urandom, core_base + 32'($urandom_range(0, MEM_BYTES - 1))});
        default: ;
      endcase
      run_word(random_legal());
    end
  endtask

  // One way of halting, then steps that find the core halted and loads that still land.
  task automatic test_halt();
    logic [31:0] w;
    case ($urandom_range(0, 4))
      0: w = W_ECALL;
      1: w = W_EBREAK;
      2: w = 32'h0;
      3: case ($urandom_range(0, 2))
           0: w = {25'($urandom_range(0, 32'h1FF_FFFF)), 7'h7F};
           1: w = enc_i(12'($urandom), 5'($urandom), 3'd3, 5'($urandom), OPC_LD);
           default: w = enc_r(7'h02, 5'($urandom), 5'($urandom), 3'($urandom), 5'd1);
         endcase
      default: w = 32'hFFFF_FFFF;
    endcase
    if (w == 32'hFFFF_FFFF) begin
      // Move memory away from the program counter so the fetch falls outside it.
      set_base(core_pc + 8);
      send_item(OPN_STEP, {$urandom, $urandom});
    end else begin
      run_word(w);
    end
    repeat (3) send_item(OPN_STEP, {$urandom, $urandom});
    send_item(OPN_LOAD, {$urandom, core_base});
    send_item(OPN_STEP, {$urandom, $urandom});
  endtask

  initial begin
    rst_n      <= 1'b0;
    cfg_tvalid <= 1'b0;
    cfg_tdata  <= '0;
    in_tvalid  <= 1'b0;
    in_tuser   <= OPN_LOAD;
    in_tdata   <= '0;
    idle_on     = 1'b1;
    error_count = 0;
    cycle_count = 0;
    steps_sent = 0;
    loads_sent = 0;
    results_seen = 0;
    core_base = BASE_RST;
    core_pc   = BASE_RST;
    core_halt = 1'b0;
    foreach (core_regs[i]) core_regs[i] = '0;
    foreach (core_mem[i]) core_mem[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_base_extremes();
    test_random_program(200);
    set_base(core_pc - 32'($urandom_range(0, MEM_BYTES - 4)));
    test_random_program(200);
    set_base(core_pc - 32'($urandom_range(0, MEM_BYTES - 4)));
    // Last stretch at full rate on both sides.
    wait_quiet();
    idle_on = 1'b0;
    test_random_program(130);
    test_halt();
    wait_quiet();

    $display("Run covered %0d steps and %0d word loads, %0d results checked, %0d mismatches.",
             steps_sent, loads_sent, results_seen, error_count);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[rv32im_instruction_step.f]
rtl/rvs_pkg.sv
rtl/rvs_front.sv
rtl/rvs_fifo.sv
rtl/rvs_div.sv
rtl/rvs_back.sv
rtl/rv32im_instruction_step.sv
test/tb_top.sv
